// File: src/abst_pkg.sv
// ----------------------------------------------------------------------------
// abst_pkg
// Shared constants, codes and control types of the array BST insert/in-order
// unit.
// ----------------------------------------------------------------------------
package abst_pkg;

	localparam int TREE_LEVELS = 10;
	localparam int KEY_BITS    = 32;

	// I/O key field width and stored key width
	localparam int KEY_IO_W = 32;
	localparam int KEY_W    = (KEY_BITS < KEY_IO_W) ? KEY_BITS : KEY_IO_W;

	localparam int STORE_SIZE = 1 << TREE_LEVELS;
	localparam int ADDR_W     = TREE_LEVELS;
	localparam int IDX_W      = TREE_LEVELS + 1;
	localparam int ROOT_IDX   = 1;

	localparam int STATUS_W = 3;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_INSERTED = 3'd0;
	localparam status_t ST_DUP      = 3'd1;
	localparam status_t ST_DEEP     = 3'd2;
	localparam status_t ST_ZERO     = 3'd3;
	localparam status_t ST_KEY      = 3'd4;
	localparam status_t ST_DONE     = 3'd5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_NEXT   = 1'b1;

	// cursor update
	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_ZERO,
		CUR_ROOT,
		CUR_END,
		CUR_LEFT,
		CUR_RIGHT,
		CUR_CHILD,
		CUR_UP
	} cur_op_t;

	// store read address select
	typedef enum logic [2:0] {
		RD_ROOT,
		RD_LEFT,
		RD_RIGHT,
		RD_CHILD,
		RD_PARENT
	} rd_sel_t;

	// source of the returned key
	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_NODE,
		SRC_RDATA
	} res_src_t;

	typedef struct packed {
		logic     take;
		logic     clr_we;
		logic     ins_we;
		logic     node_we;
		cur_op_t  cur_op;
		rd_sel_t  rd_sel;
		logic     res_we;
		status_t  res_status;
		res_src_t res_src;
		logic     out_load;
	} abst_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic op;
		logic key_zero;
		logic cur_zero;
		logic cur_end;
		logic cur_root;
		logic cur_odd;
		logic child_ok;
		logic rd_zero;
		logic rd_eq;
		logic clr_last;
		logic out_free;
	} abst_sts_t;

endpackage

// File: src/abst_if.sv
// ----------------------------------------------------------------------------
// abst_if
// Request and response channels of the array BST unit (valid/ready).
// ----------------------------------------------------------------------------
interface abst_req_if import abst_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic signed [KEY_IO_W-1:0] key;

	modport source (output valid, output op, output key, input ready);
	modport sink   (input valid, input op, input key, output ready);
endinterface

interface abst_rsp_if import abst_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [KEY_IO_W-1:0] key_out;
	status_t                    status;

	modport source (output valid, output key_out, output status, input ready);
	modport sink   (input valid, input key_out, input status, output ready);
endinterface

// File: src/abst_ram.sv
// ----------------------------------------------------------------------------
// abst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module abst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/abst_dp.sv
// ----------------------------------------------------------------------------
// abst_dp
// Datapath: request capture, walk cursor, node store, compare logic and the
// response register.
// ----------------------------------------------------------------------------
module abst_dp import abst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  abst_cmd_t  cmd,
	output abst_sts_t  sts,
	abst_req_if.sink   req,
	abst_rsp_if.source rsp
);

	logic                       op_q;
	logic [KEY_W-1:0]           key_q;
	logic [KEY_W-1:0]           node_q;
	logic [IDX_W-1:0]           cur_q;
	logic [ADDR_W-1:0]          clr_q;
	logic [KEY_W-1:0]           res_key_q;
	status_t                    res_status_q;
	logic                       out_valid_q;
	logic signed [KEY_IO_W-1:0] out_key_q;
	status_t                    out_status_q;

	logic [KEY_W-1:0]  rdata;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [KEY_W-1:0]  wdata;
	logic              we;
	logic              go_right;
	logic [IDX_W-1:0]  cur_d;
	logic [KEY_W-1:0]  res_key_d;

	abst_ram #(
		.WIDTH(KEY_W),
		.DEPTH(STORE_SIZE)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// larger keys go right
	assign go_right = !($signed(key_q) < $signed(rdata));

	always_comb begin
		we    = cmd.clr_we | cmd.ins_we;
		waddr = cmd.clr_we ? clr_q : cur_q[ADDR_W-1:0];
		wdata = cmd.clr_we ? '0 : key_q;
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_ROOT:   raddr = ADDR_W'(ROOT_IDX);
			RD_LEFT:   raddr = {cur_q[ADDR_W-2:0], 1'b0};
			RD_RIGHT:  raddr = {cur_q[ADDR_W-2:0], 1'b1};
			RD_CHILD:  raddr = {cur_q[ADDR_W-2:0], go_right};
			RD_PARENT: raddr = {1'b0, cur_q[ADDR_W-1:1]};
			default:   raddr = ADDR_W'(ROOT_IDX);
		endcase
	end

	always_comb begin
		unique case (cmd.cur_op)
			CUR_HOLD:  cur_d = cur_q;
			CUR_ZERO:  cur_d = '0;
			CUR_ROOT:  cur_d = IDX_W'(ROOT_IDX);
			CUR_END:   cur_d = IDX_W'(STORE_SIZE);
			CUR_LEFT:  cur_d = {cur_q[ADDR_W-1:0], 1'b0};
			CUR_RIGHT: cur_d = {cur_q[ADDR_W-1:0], 1'b1};
			CUR_CHILD: cur_d = {cur_q[ADDR_W-1:0], go_right};
			CUR_UP:    cur_d = cur_q >> 1;
			default:   cur_d = cur_q;
		endcase
	end

	always_comb begin
		unique case (cmd.res_src)
			SRC_ZERO:  res_key_d = '0;
			SRC_NODE:  res_key_d = node_q;
			SRC_RDATA: res_key_d = rdata;
			default:   res_key_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cur_q <= cur_d;
			if (cmd.clr_we) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && req.valid) begin
			op_q  <= req.op;
			key_q <= req.key[KEY_W-1:0];
		end
		if (cmd.node_we) begin
			node_q <= rdata;
		end
		if (cmd.res_we) begin
			res_key_q    <= res_key_d;
			res_status_q <= cmd.res_status;
		end
		if (cmd.out_load) begin
			out_key_q    <= KEY_IO_W'(signed'(res_key_q));
			out_status_q <= res_status_q;
		end
	end

	always_comb begin
		sts.in_valid = req.valid;
		sts.op       = op_q;
		sts.key_zero = (key_q == '0);
		sts.cur_zero = (cur_q == '0);
		sts.cur_end  = cur_q[IDX_W-1];
		sts.cur_root = (cur_q == IDX_W'(ROOT_IDX));
		sts.cur_odd  = cur_q[0];
		// both children of cur lie inside the store
		sts.child_ok = !cur_q[IDX_W-1] && !cur_q[ADDR_W-1];
		sts.rd_zero  = (rdata == '0);
		sts.rd_eq    = (rdata == key_q);
		sts.clr_last = (clr_q == '1);
		sts.out_free = !out_valid_q || rsp.ready;
	end

	assign req.ready   = cmd.take;
	assign rsp.valid   = out_valid_q;
	assign rsp.key_out = out_key_q;
	assign rsp.status  = out_status_q;

endmodule

// File: src/abst_ctrl.sv
// ----------------------------------------------------------------------------
// abst_ctrl
// Controller: clearing pass, insert descent and in-order successor walk.
// ----------------------------------------------------------------------------
module abst_ctrl import abst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  abst_sts_t sts,
	output abst_cmd_t cmd
);

	localparam logic [3:0] S_CLEAR     = 4'd0;
	localparam logic [3:0] S_IDLE      = 4'd1;
	localparam logic [3:0] S_DISPATCH  = 4'd2;
	localparam logic [3:0] S_INS_EVAL  = 4'd3;
	localparam logic [3:0] S_NXT_ROOT  = 4'd4;
	localparam logic [3:0] S_DESCEND   = 4'd5;
	localparam logic [3:0] S_NXT_LEFT  = 4'd6;
	localparam logic [3:0] S_NXT_RIGHT = 4'd7;
	localparam logic [3:0] S_NXT_CLIMB = 4'd8;
	localparam logic [3:0] S_NXT_FETCH = 4'd9;
	localparam logic [3:0] S_EMIT      = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.take = 1'b1;
				if (sts.in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.op == OP_INSERT) begin
					if (sts.key_zero) begin
						cmd.cur_op     = CUR_ZERO;
						cmd.res_we     = 1'b1;
						cmd.res_status = ST_ZERO;
						state_d        = S_EMIT;
					end else begin
						cmd.cur_op = CUR_ROOT;
						cmd.rd_sel = RD_ROOT;
						state_d    = S_INS_EVAL;
					end
				end else if (sts.cur_zero) begin
					cmd.rd_sel = RD_ROOT;
					state_d    = S_NXT_ROOT;
				end else if (sts.cur_end) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_DONE;
					state_d        = S_EMIT;
				end else if (sts.child_ok) begin
					cmd.rd_sel = RD_RIGHT;
					state_d    = S_NXT_RIGHT;
				end else begin
					state_d = S_NXT_CLIMB;
				end
			end
			S_INS_EVAL: begin
				// read data is the node at the cursor
				priority if (sts.rd_zero) begin
					cmd.ins_we     = 1'b1;
					cmd.cur_op     = CUR_ZERO;
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_INSERTED;
					state_d        = S_EMIT;
				end else if (sts.rd_eq) begin
					cmd.cur_op     = CUR_ZERO;
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_DUP;
					state_d        = S_EMIT;
				end else if (!sts.child_ok) begin
					cmd.cur_op     = CUR_ZERO;
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_DEEP;
					state_d        = S_EMIT;
				end else begin
					cmd.cur_op = CUR_CHILD;
					cmd.rd_sel = RD_CHILD;
				end
			end
			S_NXT_ROOT: begin
				if (sts.rd_zero) begin
					cmd.cur_op     = CUR_END;
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_DONE;
					state_d        = S_EMIT;
				end else begin
					cmd.cur_op  = CUR_ROOT;
					cmd.node_we = 1'b1;
					state_d     = S_DESCEND;
				end
			end
			S_DESCEND: begin
				if (sts.child_ok) begin
					cmd.rd_sel = RD_LEFT;
					state_d    = S_NXT_LEFT;
				end else begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_KEY;
					cmd.res_src    = SRC_NODE;
					state_d        = S_EMIT;
				end
			end
			S_NXT_LEFT: begin
				if (!sts.rd_zero) begin
					cmd.cur_op  = CUR_LEFT;
					cmd.node_we = 1'b1;
					state_d     = S_DESCEND;
				end else begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_KEY;
					cmd.res_src    = SRC_NODE;
					state_d        = S_EMIT;
				end
			end
			S_NXT_RIGHT: begin
				if (!sts.rd_zero) begin
					cmd.cur_op  = CUR_RIGHT;
					cmd.node_we = 1'b1;
					state_d     = S_DESCEND;
				end else begin
					state_d = S_NXT_CLIMB;
				end
			end
			S_NXT_CLIMB: begin
				// climb while the cursor is a right child
				priority if (sts.cur_root) begin
					cmd.cur_op     = CUR_END;
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_DONE;
					state_d        = S_EMIT;
				end else if (sts.cur_odd) begin
					cmd.cur_op = CUR_UP;
				end else begin
					cmd.cur_op = CUR_UP;
					cmd.rd_sel = RD_PARENT;
					state_d    = S_NXT_FETCH;
				end
			end
			S_NXT_FETCH: begin
				cmd.res_we     = 1'b1;
				cmd.res_status = ST_KEY;
				cmd.res_src    = SRC_RDATA;
				state_d        = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: src/array_bst_insert_inorder_unit.sv
// ----------------------------------------------------------------------------
// array_bst_insert_inorder_unit
// Binary search tree in a heap-indexed node store with insert and in-order
// read-out.
//
// The req channel carries one request: op (insert or next) and a signed key.
// The rsp channel returns exactly one response per request: key_out and a
// status (inserted, duplicate, dropped too deep, zero rejected, key, finished).
// Requests are taken one at a time; req.ready is high only while the unit is
// idle. An insert walks d levels, where d is 1 to TREE_LEVELS, one store read
// per level; a zero key is rejected without a store read. A next request
// finds the successor by descending left, one store read per level, or by
// climbing one level per step. After reset the unit sweeps the
// 2^TREE_LEVELS store entries to zero, one per cycle, and accepts no request
// until the sweep is done.
// A response sits in the output register until rsp.ready; a finished request
// waits for that register to free up before returning to idle.
// ----------------------------------------------------------------------------
module array_bst_insert_inorder_unit import abst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	abst_req_if.sink   req,
	abst_rsp_if.source rsp
);

	abst_cmd_t cmd;
	abst_sts_t sts;

	abst_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	abst_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.req   (req),
		.rsp   (rsp)
	);

endmodule
